// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int ValueWidth = 32;
	localparam int PriWidth   = 16;
	localparam int OccWidth   = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                  vld;
		logic [ValueWidth-1:0] value;
		logic [PriWidth-1:0]   pri;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic                ins;
		logic                rem;
		logic [ValueWidth-1:0] value;
		logic [PriWidth-1:0] pri;
	} cell_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_gt,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               gt
);

	spq_pkg::entry_t entry_q;

	// this slot is empty or holds a strictly larger priority number
	assign gt    = !entry_q.vld || (entry_q.pri > cmd.pri);
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.ins && gt) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else begin
				entry_q.vld   <= 1'b1;
				entry_q.value <= cmd.value;
				entry_q.pri   <= cmd.pri;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Bounded stable priority queue built as a row of CAPACITY cells kept sorted by
// priority number; equal priorities leave in arrival order. Every cell compares
// its own priority against the incoming one in parallel and shifts by one slot,
// so busy never rises, an item can be issued on every clock, and its result
// appears on the next cycle with done high for that one cycle. Inserts into
// a full queue report status 2, removes from an empty queue report status 1;
// occupancy is the stored count after the item, low five bits.
module stable_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [31:0] item_value,
	input  logic        [15:0] item_priority,
	output logic               done,
	output logic signed [31:0] out_value,
	output logic        [15:0] out_priority,
	output logic        [1:0]  status,
	output logic        [4:0]  occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int OW = (CW > spq_pkg::OccWidth) ? CW : spq_pkg::OccWidth;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               accept;
	logic               is_remove;
	logic               full;
	logic               empty;
	spq_pkg::cell_cmd_t cmd;
	spq_pkg::entry_t    entries [CAPACITY];
	logic               gts     [CAPACITY];

	logic                        done_q;
	logic [spq_pkg::ValueWidth-1:0] value_q;
	logic [spq_pkg::PriWidth-1:0]   pri_q;
	spq_pkg::status_t            status_q;
	logic [OW-1:0]               occ_q;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign is_remove = (operation == spq_pkg::OP_REMOVE);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	always_comb begin
		cmd.ins   = accept && !is_remove && !full;
		cmd.rem   = accept && is_remove && !empty;
		cmd.value = item_value;
		cmd.pri   = item_priority;
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.rem) begin
			count_next = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_g;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_g = gts[i-1];
		end

		// vacated back slot fills with zeros
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e),
			.left_gt     (left_g),
			.right_entry (right_e),
			.entry       (entries[i]),
			.gt          (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= '0;
			pri_q    <= '0;
			status_q <= spq_pkg::ST_DONE;
			occ_q    <= OW'(count_next);
			if (is_remove) begin
				if (empty) begin
					status_q <= spq_pkg::ST_EMPTY;
				end else begin
					value_q <= entries[0].value;
					pri_q   <= entries[0].pri;
				end
			end else if (full) begin
				status_q <= spq_pkg::ST_FULL;
			end
		end
	end

	assign done         = done_q;
	assign out_value    = value_q;
	assign out_priority = pri_q;
	assign status       = status_q;
	assign occupancy    = occ_q[spq_pkg::OccWidth-1:0];

endmodule
